@@ rtl/core/marquee_scroll_window_macros.svh @@
// ----------------------------------------------------------------------------
// marquee_scroll_window assertion macros
// shared concurrent check forms, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MARQUEE_SCROLL_WINDOW_MACROS_SVH
`define MARQUEE_SCROLL_WINDOW_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, quiet during reset
`define MQSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marquee_scroll_window: check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define MQSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marquee_scroll_window: check failed");

`else

`define MQSW_ASSERT_NOW(label, ante, cons)
`define MQSW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/mqsw_pkg.sv @@
// ----------------------------------------------------------------------------
// mqsw_pkg
// beat types, case codes and fixed widths of the marquee scroll window
// ----------------------------------------------------------------------------
`default_nettype none

package mqsw_pkg;

    localparam int WIDTH_BITS  = 12;
    localparam int SPACER_BITS = 8;
    localparam int INDEX_BITS  = 64;

    // holds 2*(text-window)+4 and text+spacer
    localparam int DIV_BITS = ((WIDTH_BITS > SPACER_BITS) ? WIDTH_BITS : SPACER_BITS) + 2;

    localparam int PAUSE_TICKS    = 2;
    localparam int ELLIPSIS_CHARS = 3;

    localparam logic KIND_BOUNCE = 1'b0;
    localparam logic KIND_LOOP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIT    = 2'd0,
        MODE_TRUNC  = 2'd1,
        MODE_BOUNCE = 2'd2,
        MODE_LOOP   = 2'd3
    } mqsw_mode_t;

    typedef struct packed {
        logic                   kind;
        logic [INDEX_BITS-1:0]  tick_index;
        logic [WIDTH_BITS-1:0]  window_width;
        logic [WIDTH_BITS-1:0]  text_width;
        logic [SPACER_BITS-1:0] spacer_len;
        logic                   selected;
    } mqsw_in_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  first_offset;
        logic [WIDTH_BITS-1:0]  first_width;
        logic [SPACER_BITS-1:0] gap_offset;
        logic [SPACER_BITS-1:0] gap_width;
        logic [WIDTH_BITS-1:0]  wrap_width;
        logic                   ellipsis;
        logic                   scrolling;
    } mqsw_out_t;

    // what travels down the divider chain
    typedef struct packed {
        mqsw_mode_t             mode;
        logic [INDEX_BITS-1:0]  dividend;
        logic [DIV_BITS-1:0]    rem;
        logic [DIV_BITS-1:0]    divisor;
        logic [WIDTH_BITS-1:0]  win;
        logic [WIDTH_BITS-1:0]  txt;
        logic [SPACER_BITS-1:0] spc;
    } mqsw_div_t;

endpackage

`default_nettype wire

@@ rtl/core/mqsw_cell.sv @@
// ----------------------------------------------------------------------------
// mqsw_cell
// one restoring division step: takes the next tick bit into the remainder
// ----------------------------------------------------------------------------
`default_nettype none

module mqsw_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               enable,
    input  wire logic               valid_in,
    input  wire mqsw_pkg::mqsw_div_t data_in,
    output logic                    valid_out,
    output mqsw_pkg::mqsw_div_t     data_out
);
    import mqsw_pkg::*;

    logic                valid_reg;
    mqsw_div_t           data_reg;
    mqsw_div_t           data_next;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS:0]   diff;

    always_comb
    begin
        trial     = {data_in.rem, data_in.dividend[INDEX_BITS-1]};
        diff      = trial - {1'b0, data_in.divisor};
        data_next = data_in;
        data_next.dividend = {data_in.dividend[INDEX_BITS-2:0], 1'b0};
        if (trial >= {1'b0, data_in.divisor})
        begin
            data_next.rem = diff[DIV_BITS-1:0];
        end
        else
        begin
            data_next.rem = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/mqsw_finish.sv @@
// ----------------------------------------------------------------------------
// mqsw_finish
// turns the phase left by the divider chain into visible segments
// ----------------------------------------------------------------------------
`default_nettype none

module mqsw_finish (
    input  wire mqsw_pkg::mqsw_div_t data_in,
    output mqsw_pkg::mqsw_out_t      result
);
    import mqsw_pkg::*;

    logic [DIV_BITS-1:0] p;
    logic [DIV_BITS-1:0] win_e;
    logic [DIV_BITS-1:0] txt_e;
    logic [DIV_BITS-1:0] spc_e;
    logic [DIV_BITS-1:0] span;
    logic [DIV_BITS-1:0] bounce_off;
    logic                below;
    logic [DIV_BITS-1:0] o1;
    logic [DIV_BITS-1:0] w1_raw;
    logic [DIV_BITS-1:0] w1;
    logic [DIV_BITS-1:0] o2;
    logic [DIV_BITS-1:0] room;
    logic [DIV_BITS-1:0] w2_raw;
    logic [DIV_BITS-1:0] w2;
    logic [DIV_BITS-1:0] w3;
    logic [WIDTH_BITS-1:0] trunc_w;

    always_comb
    begin
        p     = data_in.rem;
        win_e = DIV_BITS'(data_in.win);
        txt_e = DIV_BITS'(data_in.txt);
        spc_e = DIV_BITS'(data_in.spc);

        // bounce: rest, slide right, rest, slide back
        span = txt_e - win_e;
        if (p < DIV_BITS'(PAUSE_TICKS))
        begin
            bounce_off = '0;
        end
        else if (p < span + DIV_BITS'(PAUSE_TICKS))
        begin
            bounce_off = p - DIV_BITS'(PAUSE_TICKS);
        end
        else if (p < span + DIV_BITS'(2 * PAUSE_TICKS))
        begin
            bounce_off = span;
        end
        else
        begin
            bounce_off = data_in.divisor - p;
        end

        // loop: text tail, spacer, text head
        below  = p < txt_e;
        o1     = below ? p : '0;
        w1_raw = below ? (txt_e - p) : '0;
        w1     = (w1_raw > win_e) ? win_e : w1_raw;
        o2     = (p > txt_e) ? (p - txt_e) : '0;
        room   = win_e - w1;
        w2_raw = spc_e - o2;
        w2     = (w2_raw > room) ? room : w2_raw;
        w3     = win_e - w1 - w2;

        if (data_in.win >= WIDTH_BITS'(ELLIPSIS_CHARS))
        begin
            trunc_w = data_in.win - WIDTH_BITS'(ELLIPSIS_CHARS);
        end
        else
        begin
            trunc_w = '0;
        end

        result = '0;
        case (data_in.mode)
            MODE_FIT:
            begin
                result.first_width = data_in.txt;
            end
            MODE_TRUNC:
            begin
                result.first_width = trunc_w;
                result.ellipsis    = 1'b1;
            end
            MODE_BOUNCE:
            begin
                result.first_offset = bounce_off[WIDTH_BITS-1:0];
                result.first_width  = data_in.win;
                result.scrolling    = 1'b1;
            end
            MODE_LOOP:
            begin
                result.first_offset = o1[WIDTH_BITS-1:0];
                result.first_width  = w1[WIDTH_BITS-1:0];
                result.gap_offset   = o2[SPACER_BITS-1:0];
                result.gap_width    = w2[SPACER_BITS-1:0];
                result.wrap_width   = w3[WIDTH_BITS-1:0];
                result.scrolling    = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/marquee_scroll_window.sv @@
// ----------------------------------------------------------------------------
// marquee_scroll_window
// visible text, spacer and wrap segments of a scrolling label
// ----------------------------------------------------------------------------
// Takes one beat per clock while item_stall is low and returns one result
// beat per item, in order, through 66 register stages: one setup stage that
// picks the case and the period, a chain of 64 cells that each take one tick
// bit into the running remainder of tick mod period, and the output register
// where the segments are formed. A two-entry output buffer lets the chain
// keep moving while a result waits; item_stall rises only when both entries
// are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marquee_scroll_window_macros.svh"

module marquee_scroll_window (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire mqsw_pkg::mqsw_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output mqsw_pkg::mqsw_out_t      result
);
    import mqsw_pkg::*;

    logic        enable;
    logic        prep_valid_reg;
    mqsw_div_t   prep_data_reg;
    mqsw_div_t   prep_data_next;
    logic        cell_valid [0:INDEX_BITS];
    mqsw_div_t   cell_data  [0:INDEX_BITS];
    mqsw_out_t   finished;
    logic        out_valid_reg;
    mqsw_out_t   out_data_reg;
    logic        skid_valid_reg;
    mqsw_out_t   skid_data_reg;
    logic        take;
    logic        push;
    logic [WIDTH_BITS-1:0] span;

    assign enable = !skid_valid_reg;
    assign take   = out_valid_reg && !result_stall;
    assign push   = enable && cell_valid[INDEX_BITS];

    // case selection and period
    always_comb
    begin
        span = item.text_width - item.window_width;
        prep_data_next          = '0;
        prep_data_next.dividend = item.tick_index;
        prep_data_next.win      = item.window_width;
        prep_data_next.txt      = item.text_width;
        prep_data_next.spc      = item.spacer_len;
        prep_data_next.divisor  = DIV_BITS'(1);
        if (item.text_width <= item.window_width)
        begin
            prep_data_next.mode = MODE_FIT;
        end
        else if (!item.selected)
        begin
            prep_data_next.mode = MODE_TRUNC;
        end
        else if (item.kind == KIND_BOUNCE)
        begin
            prep_data_next.mode    = MODE_BOUNCE;
            prep_data_next.divisor = DIV_BITS'({span, 1'b0})
                                     + DIV_BITS'(2 * PAUSE_TICKS);
        end
        else
        begin
            prep_data_next.mode    = MODE_LOOP;
            prep_data_next.divisor = DIV_BITS'(item.text_width)
                                     + DIV_BITS'(item.spacer_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            prep_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            prep_data_reg <= prep_data_next;
        end
    end

    assign cell_valid[0] = prep_valid_reg;
    assign cell_data[0]  = prep_data_reg;

    for (genvar i = 0; i < INDEX_BITS; i++)
    begin : g_cell
        mqsw_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (enable),
            .valid_in  (cell_valid[i]),
            .data_in   (cell_data[i]),
            .valid_out (cell_valid[i+1]),
            .data_out  (cell_data[i+1])
        );
    end

    mqsw_finish u_finish (
        .data_in (cell_data[INDEX_BITS]),
        .result  (finished)
    );

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= finished;
            end
            else
            begin
                out_data_reg <= finished;
            end
        end
    end

    assign item_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `MQSW_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `MQSW_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !result_stall, out_valid_reg && !skid_valid_reg)
    `MQSW_ASSERT_NOW(a_skid_fill_cause, $rose(skid_valid_reg), $past(out_valid_reg && result_stall))
    `MQSW_ASSERT_NOW(a_rem_below_period, cell_valid[INDEX_BITS], cell_data[INDEX_BITS].rem < cell_data[INDEX_BITS].divisor)

endmodule

`default_nettype wire

@@ tb/tb_marquee_scroll_window.sv @@
// ----------------------------------------------------------------------------
// tb_marquee_scroll_window
// self-checking bench for the marquee scroll window
// ----------------------------------------------------------------------------
// Drives label beats with bursty gaps against a receiver that stalls on its
// own pattern, with one long output hold that backs the pipeline up to its
// input. A short directed table covers fitting, truncated, bounce and loop
// labels at the field extremes. A long random run follows. Every result beat
// is checked field by field against its table row or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_marquee_scroll_window;

    import mqsw_pkg::*;

    localparam int RANDOM_LABELS = 1750;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 500;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        mqsw_in_t  beat;
        logic      typed;
        mqsw_out_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    mqsw_in_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    mqsw_out_t result;

    mqsw_in_t  label_beats [$];
    logic      want_typed [$];
    mqsw_out_t typed_wants [$];
    mqsw_out_t segments_due [$];

    stim_row_t directed_rows [DIRECTED_ROWS];

    int accepted_n = 0;
    int results_n = 0;
    int fault_count = 0;
    int cycle_count = 0;
    int mode_seen [4] = '{0, 0, 0, 0};

    marquee_scroll_window dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic mqsw_mode_t label_mode(mqsw_in_t b);
        if (b.text_width <= b.window_width)
        begin
            return MODE_FIT;
        end
        if (!b.selected)
        begin
            return MODE_TRUNC;
        end
        if (b.kind == KIND_BOUNCE)
        begin
            return MODE_BOUNCE;
        end
        return MODE_LOOP;
    endfunction

    function automatic mqsw_out_t visible_segments(mqsw_in_t b);
        mqsw_out_t   s;
        logic [63:0] win, txt, spc, d, p, off, w1, o2, w2;
        s   = '0;
        win = b.window_width;
        txt = b.text_width;
        spc = b.spacer_len;
        case (label_mode(b))
            MODE_FIT:
            begin
                s.first_width = b.text_width;
            end
            MODE_TRUNC:
            begin
                s.first_width = (win >= ELLIPSIS_CHARS) ? WIDTH_BITS'(win - ELLIPSIS_CHARS) : '0;
                s.ellipsis    = 1'b1;
            end
            MODE_BOUNCE:
            begin
                d = txt - win;
                p = b.tick_index % (2 * d + 2 * PAUSE_TICKS);
                // rest, slide right, rest, slide back
                if (p < PAUSE_TICKS)
                begin
                    off = 0;
                end
                else if (p < d + PAUSE_TICKS)
                begin
                    off = p - PAUSE_TICKS;
                end
                else if (p < d + 2 * PAUSE_TICKS)
                begin
                    off = d;
                end
                else
                begin
                    off = d - (p - d - 2 * PAUSE_TICKS);
                end
                s.first_offset = off[WIDTH_BITS-1:0];
                s.first_width  = b.window_width;
                s.scrolling    = 1'b1;
            end
            MODE_LOOP:
            begin
                p  = b.tick_index % (txt + spc);
                w1 = (p < txt) ? txt - p : 64'd0;
                if (w1 > win)
                begin
                    w1 = win;
                end
                o2 = (p > txt) ? p - txt : 64'd0;
                w2 = spc - o2;
                // spacer is bounded by what the text leaves of the window
                if (w2 > win - w1)
                begin
                    w2 = win - w1;
                end
                s.first_offset = (p < txt) ? p[WIDTH_BITS-1:0] : '0;
                s.first_width  = w1[WIDTH_BITS-1:0];
                s.gap_offset   = o2[SPACER_BITS-1:0];
                s.gap_width    = w2[SPACER_BITS-1:0];
                s.wrap_width   = WIDTH_BITS'(win - w1 - w2);
                s.scrolling    = 1'b1;
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

    function automatic mqsw_in_t random_label();
        mqsw_in_t    b;
        int unsigned pick, room, d;
        logic [63:0] period;
        b.kind         = $urandom_range(0, 1);
        b.selected     = 1'b1;
        b.spacer_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 255);
        b.tick_index   = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            b.window_width = $urandom_range(0, 4095);
            b.text_width   = $urandom_range(0, b.window_width);
            b.selected     = $urandom_range(0, 1);
        end
        else
        begin
            b.window_width = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4094)
                                                          : $urandom_range(0, 40);
            room = 4095 - b.window_width;
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, room)
                                             : $urandom_range(1, (room < 12) ? room : 12);
            b.text_width = b.window_width + d;
            if (pick < 24)
            begin
                b.selected = 1'b0;
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                // small ticks walk every phase of a short period
                period = (b.kind == KIND_BOUNCE) ? 2 * d + 2 * PAUSE_TICKS
                                                  : b.text_width + b.spacer_len;
                b.tick_index = $urandom_range(0, 3 * period);
            end
        end
        return b;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_marquee_scroll_window: errors");
            $finish;
        end
        else
        begin
            cycle_count++;
        end
    end

    // accepted beats on both sides
    always @(posedge clk)
    begin : watch
        mqsw_out_t due;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                if (want_typed[accepted_n])
                begin
                    segments_due.push_back(typed_wants[accepted_n]);
                end
                else
                begin
                    segments_due.push_back(visible_segments(label_beats[accepted_n]));
                end
                mode_seen[int'(label_mode(label_beats[accepted_n]))]++;
                accepted_n++;
            end
            if (result_valid && !result_stall)
            begin
                results_n++;
                if (segments_due.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fault_count++;
                end
                else
                begin
                    due = segments_due.pop_front();
                    check_field("first_offset", due.first_offset, result.first_offset);
                    check_field("first_width", due.first_width, result.first_width);
                    check_field("gap_offset", due.gap_offset, result.gap_offset);
                    check_field("gap_width", due.gap_width, result.gap_width);
                    check_field("wrap_width", due.wrap_width, result.wrap_width);
                    check_field("ellipsis", due.ellipsis, result.ellipsis);
                    check_field("scrolling", due.scrolling, result.scrolling);
                end
            end
        end
    end

    // sender: bursts of beats with gaps, payload held while stalled
    initial
    begin : feed
        int burst_left;
        int gap_left;
        int offered;
        burst_left = 0;
        gap_left   = 0;
        offered    = -1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!item_valid || accepted_n > offered)
            begin
                if (gap_left > 0 || accepted_n >= label_beats.size())
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    item_valid <= 1'b0;
                end
                else
                begin
                    item_valid <= 1'b1;
                    item       <= label_beats[accepted_n];
                    offered    = accepted_n;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                                  : $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                                : $urandom_range(0, 5);
                    end
                end
            end
        end
    end

    // receiver: rotating stall patterns plus one long hold
    initial
    begin : drain
        int hold_left;
        int stall_tick;
        bit held;
        hold_left  = 0;
        stall_tick = 0;
        held       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && results_n >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case ((results_n / 160) % 4)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 9) < 7);
                    default: result_stall <= ((stall_tick % 7) < 3);
                endcase
            end
            stall_tick++;
        end
    end

    initial
    begin : main
        directed_rows = '{
            // fitting labels
            '{'{KIND_BOUNCE, 64'd0, 12'd0, 12'd0, 8'd0, 1'b0}, 1'b1,
              '{12'd0, 12'd0, 8'd0, 8'd0, 12'd0, 1'b0, 1'b0}},
            '{'{KIND_LOOP, '1, 12'd4095, 12'd4095, 8'd255, 1'b1}, 1'b1,
              '{12'd0, 12'd4095, 8'd0, 8'd0, 12'd0, 1'b0, 1'b0}},
            '{'{KIND_BOUNCE, 64'd77, 12'd4095, 12'd5, 8'd9, 1'b1}, 1'b1,
              '{12'd0, 12'd5, 8'd0, 8'd0, 12'd0, 1'b0, 1'b0}},
            // truncated with ellipsis
            '{'{KIND_LOOP, 64'd0, 12'd0, 12'd1, 8'd0, 1'b0}, 1'b1,
              '{12'd0, 12'd0, 8'd0, 8'd0, 12'd0, 1'b1, 1'b0}},
            '{'{KIND_BOUNCE, '1, 12'd2, 12'd4095, 8'd255, 1'b0}, 1'b1,
              '{12'd0, 12'd0, 8'd0, 8'd0, 12'd0, 1'b1, 1'b0}},
            '{'{KIND_LOOP, 64'd5, 12'd3, 12'd10, 8'd4, 1'b0}, 1'b1,
              '{12'd0, 12'd0, 8'd0, 8'd0, 12'd0, 1'b1, 1'b0}},
            '{'{KIND_BOUNCE, 64'd9, 12'd4094, 12'd4095, 8'd0, 1'b0}, 1'b1,
              '{12'd0, 12'd4091, 8'd0, 8'd0, 12'd0, 1'b1, 1'b0}},
            // bounce over one period: both rests and both slides
            '{'{KIND_BOUNCE, 64'd0, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd1, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd2, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd5, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd6, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd7, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, 64'd9, 12'd5, 12'd8, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_BOUNCE, '1, 12'd0, 12'd4095, 8'd255, 1'b1}, 1'b0, '0},
            // loop: text, spacer, wrap back to text start
            '{'{KIND_LOOP, 64'd0, 12'd4, 12'd10, 8'd3, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, 64'd8, 12'd4, 12'd10, 8'd3, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, 64'd10, 12'd4, 12'd10, 8'd3, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, 64'd12, 12'd4, 12'd10, 8'd3, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, 64'd5, 12'd4, 12'd10, 8'd0, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, '1, 12'd0, 12'd4095, 8'd255, 1'b1}, 1'b0, '0},
            '{'{KIND_LOOP, 64'd4095, 12'd4094, 12'd4095, 8'd255, 1'b1}, 1'b0, '0}
        };
        foreach (directed_rows[i])
        begin
            label_beats.push_back(directed_rows[i].beat);
            want_typed.push_back(directed_rows[i].typed);
            typed_wants.push_back(directed_rows[i].want);
        end
        repeat (RANDOM_LABELS)
        begin
            label_beats.push_back(random_label());
            want_typed.push_back(1'b0);
            typed_wants.push_back('0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted_n == label_beats.size());
        wait (segments_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (segments_due.size() != 0)
        begin
            $error("%0d expected result beats never arrived", segments_due.size());
            fault_count++;
        end

        $display("labels sent %0d: fit %0d, truncated %0d, bounce %0d, loop %0d",
                 accepted_n, mode_seen[int'(MODE_FIT)], mode_seen[int'(MODE_TRUNC)],
                 mode_seen[int'(MODE_BOUNCE)], mode_seen[int'(MODE_LOOP)]);
        $display("result beats checked %0d, including a %0d cycle output hold",
                 results_n, HOLD_CYCLES);
        if (fault_count == 0)
        begin
            $display("tb_marquee_scroll_window: clean");
        end
        else
        begin
            $display("tb_marquee_scroll_window: errors");
        end
        $finish;
    end

endmodule
